### design/psw_pkg.sv
// Package for the priority schedule wait-time block.
// Holds field widths and the command and status structs shared by the
// controller and the datapath. Depends on nothing.
package psw_pkg;

    localparam int PRIO_W  = 16;
    localparam int BURST_W = 16;
    localparam int NUM_W   = 7;
    localparam int WAIT_W  = 22;
    localparam int TOTAL_W = 28;

    typedef struct packed {
        logic load;
        logic drop;
        logic probe;
        logic shift;
        logic put;
        logic emit_start;
        logic emit_read;
        logic emit_fill;
        logic emit_next;
        logic finish;
    } psw_cmd_t;

    typedef struct packed {
        logic full;
        logic pos_zero;
        logic pos_one;
        logic greater;
        logic last_item;
        logic emit_last;
    } psw_status_t;

endpackage

### design/psw_job_if.sv
// Input channel carrying one job per item with a valid/ready handshake.
// Depends on psw_pkg for the field widths.
interface psw_job_if;
    logic                       valid;
    logic                       ready;
    logic [psw_pkg::PRIO_W-1:0]  job_priority;
    logic [psw_pkg::BURST_W-1:0] burst_time;
    logic                       last_job;

    modport source (output valid, output job_priority, output burst_time,
                    output last_job, input ready);
    modport sink   (input valid, input job_priority, input burst_time,
                    input last_job, output ready);
endinterface

### design/psw_result_if.sv
// Output channel carrying one served job per item with a valid/ready handshake.
// Depends on psw_pkg for the field widths.
interface psw_result_if;
    logic                       valid;
    logic                       ready;
    logic [psw_pkg::NUM_W-1:0]   job_number;
    logic [psw_pkg::PRIO_W-1:0]  out_priority;
    logic [psw_pkg::BURST_W-1:0] out_burst;
    logic [psw_pkg::WAIT_W-1:0]  wait_time;
    logic [psw_pkg::WAIT_W-1:0]  turnaround_time;
    logic [psw_pkg::TOTAL_W-1:0] total_wait;
    logic [psw_pkg::TOTAL_W-1:0] total_turnaround;
    logic                       overflow_flag;
    logic                       last_result;

    modport source (output valid, output job_number, output out_priority,
                    output out_burst, output wait_time, output turnaround_time,
                    output total_wait, output total_turnaround,
                    output overflow_flag, output last_result, input ready);
    modport sink   (input valid, input job_number, input out_priority,
                    input out_burst, input wait_time, input turnaround_time,
                    input total_wait, input total_turnaround,
                    input overflow_flag, input last_result, output ready);
endinterface

### design/priority_schedule_wait_times_core.sv
// Top level of the non-preemptive priority scheduler wait-time block.
// Joins psw_ctrl and psw_datapath; depends on psw_pkg, psw_job_if, psw_result_if.
//
// Usage: jobs arrive on the job channel, one item per job, carrying a
// priority and a burst time. Each job is inserted into a sorted store by
// walking it from the top and moving larger priorities up one place per
// cycle, through the single read and single write port of the job store.
// Ties keep arrival order. Jobs beyond MAX_JOBS are dropped and flagged.
// On the item marked last, the set is emitted on the result channel in
// service order, one item per stored job, each built by a store read, an
// accumulate and a send once the receiver is ready. The final item carries
// the totals and the last_result mark; the set is then cleared. While
// results are being sent no job is accepted. If the receiver stalls, the
// current result is held unchanged until it is taken.
// Reset clears the job count and the dropped mark and returns to accepting
// jobs; the store contents are not cleared and need no clearing pass.
module priority_schedule_wait_times_core
#(
    parameter int MAX_JOBS  = 64,
    parameter int TIME_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    psw_job_if.sink      job,
    psw_result_if.source result
);

    psw_pkg::psw_cmd_t    cmd;
    psw_pkg::psw_status_t status;

    psw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job.valid),
        .out_ready (result.ready),
        .status    (status),
        .in_ready  (job.ready),
        .out_valid (result.valid),
        .cmd       (cmd)
    );

    psw_datapath
    #(
        .MAX_JOBS  (MAX_JOBS),
        .TIME_BITS (TIME_BITS)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .job_priority     (job.job_priority),
        .burst_time       (job.burst_time),
        .last_job         (job.last_job),
        .job_number       (result.job_number),
        .out_priority     (result.out_priority),
        .out_burst        (result.out_burst),
        .wait_time        (result.wait_time),
        .turnaround_time  (result.turnaround_time),
        .total_wait       (result.total_wait),
        .total_turnaround (result.total_turnaround),
        .overflow_flag    (result.overflow_flag),
        .last_result      (result.last_result)
    );

endmodule

### design/psw_ctrl.sv
// Controller state machine for the priority schedule wait-time block.
// Sequences insertion and emission; depends on psw_pkg for commands and status.
module psw_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_ready,
    input  psw_pkg::psw_status_t status,
    output logic                 in_ready,
    output logic                 out_valid,
    output psw_pkg::psw_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_PUT,
        S_EMIT_RD,
        S_EMIT_FILL,
        S_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.full)
                begin
                    cmd.drop = 1'b1;
                    cmd.emit_start = status.last_item;
                    state_next = status.last_item ? S_EMIT_RD : S_IDLE;
                end
                else if (status.pos_zero)
                begin
                    cmd.put = 1'b1;
                    cmd.emit_start = status.last_item;
                    state_next = status.last_item ? S_EMIT_RD : S_IDLE;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (status.greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = status.pos_one ? S_PUT : S_CMP;
                end
                else
                begin
                    cmd.put = 1'b1;
                    cmd.emit_start = status.last_item;
                    state_next = status.last_item ? S_EMIT_RD : S_IDLE;
                end
            end
            S_PUT:
            begin
                cmd.put = 1'b1;
                cmd.emit_start = status.last_item;
                state_next = status.last_item ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = S_EMIT_FILL;
            end
            S_EMIT_FILL:
            begin
                cmd.emit_fill = 1'b1;
                state_next    = S_SEND;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    if (status.emit_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_IDLE);
            out_valid_reg <= (state_next == S_SEND);
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

### design/psw_datapath.sv
// Datapath for the priority schedule wait-time block: the sorted job stores,
// the insertion pointer, the time accumulators and the result register.
// Depends on psw_pkg; driven by commands from psw_ctrl.
module psw_datapath
#(
    parameter int MAX_JOBS  = 64,
    parameter int TIME_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  psw_pkg::psw_cmd_t            cmd,
    output psw_pkg::psw_status_t         status,
    input  logic [psw_pkg::PRIO_W-1:0]   job_priority,
    input  logic [psw_pkg::BURST_W-1:0]  burst_time,
    input  logic                         last_job,
    output logic [psw_pkg::NUM_W-1:0]    job_number,
    output logic [psw_pkg::PRIO_W-1:0]   out_priority,
    output logic [psw_pkg::BURST_W-1:0]  out_burst,
    output logic [psw_pkg::WAIT_W-1:0]   wait_time,
    output logic [psw_pkg::WAIT_W-1:0]   turnaround_time,
    output logic [psw_pkg::TOTAL_W-1:0]  total_wait,
    output logic [psw_pkg::TOTAL_W-1:0]  total_turnaround,
    output logic                         overflow_flag,
    output logic                         last_result
);

    localparam int SW = (TIME_BITS < psw_pkg::PRIO_W) ? TIME_BITS : psw_pkg::PRIO_W;
    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int TW = psw_pkg::TOTAL_W;

    logic [SW-1:0] prio_mem  [MAX_JOBS];
    logic [SW-1:0] burst_mem [MAX_JOBS];
    logic [CW-1:0] num_mem   [MAX_JOBS];

    logic [SW-1:0] rd_prio_reg;
    logic [SW-1:0] rd_burst_reg;
    logic [CW-1:0] rd_num_reg;

    logic [SW-1:0] new_prio_reg;
    logic [SW-1:0] new_burst_reg;
    logic          new_last_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] k_reg;
    logic [CW-1:0] count_reg;
    logic          dropped_reg;

    logic [TW-1:0] acc_reg;
    logic [TW-1:0] tot_wait_reg;
    logic [TW-1:0] tot_turn_reg;

    logic [psw_pkg::NUM_W-1:0]   job_number_reg;
    logic [psw_pkg::PRIO_W-1:0]  out_priority_reg;
    logic [psw_pkg::BURST_W-1:0] out_burst_reg;
    logic [psw_pkg::WAIT_W-1:0]  wait_time_reg;
    logic [psw_pkg::WAIT_W-1:0]  turnaround_time_reg;
    logic [psw_pkg::TOTAL_W-1:0] total_wait_reg;
    logic [psw_pkg::TOTAL_W-1:0] total_turnaround_reg;
    logic                        overflow_flag_reg;
    logic                        last_result_reg;

    logic          wr_en;
    logic [SW-1:0] wr_prio;
    logic [SW-1:0] wr_burst;
    logic [CW-1:0] wr_num;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [TW-1:0] turn;
    logic          is_last;

    assign wr_en    = cmd.shift || cmd.put;
    assign wr_prio  = cmd.shift ? rd_prio_reg  : new_prio_reg;
    assign wr_burst = cmd.shift ? rd_burst_reg : new_burst_reg;
    assign wr_num   = cmd.shift ? rd_num_reg   : count_reg + CW'(1);

    assign rd_en = cmd.probe || (cmd.shift && !status.pos_one) || cmd.emit_read;

    always_comb
    begin
        priority if (cmd.emit_read)
        begin
            rd_addr = k_reg;
        end
        else if (cmd.probe)
        begin
            rd_addr = pos_reg - AW'(1);
        end
        else
        begin
            rd_addr = pos_reg - AW'(2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prio_mem[pos_reg]  <= wr_prio;
            burst_mem[pos_reg] <= wr_burst;
            num_mem[pos_reg]   <= wr_num;
        end
        if (rd_en)
        begin
            rd_prio_reg  <= prio_mem[rd_addr];
            rd_burst_reg <= burst_mem[rd_addr];
            rd_num_reg   <= num_mem[rd_addr];
        end
    end

    assign turn    = acc_reg + TW'(rd_burst_reg);
    assign is_last = (CW'(k_reg) == count_reg - CW'(1));

    assign status.full      = (count_reg == CW'(MAX_JOBS));
    assign status.pos_zero  = (pos_reg == '0);
    assign status.pos_one   = (pos_reg == AW'(1));
    assign status.greater   = (rd_prio_reg > new_prio_reg);
    assign status.last_item = new_last_reg;
    assign status.emit_last = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            else
            begin
                if (cmd.put)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                if (cmd.drop)
                begin
                    dropped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_prio_reg  <= job_priority[SW-1:0];
            new_burst_reg <= burst_time[SW-1:0];
            new_last_reg  <= last_job;
            pos_reg       <= count_reg[AW-1:0];
        end
        else if (cmd.shift)
        begin
            pos_reg <= pos_reg - AW'(1);
        end

        if (cmd.emit_start)
        begin
            k_reg        <= '0;
            acc_reg      <= '0;
            tot_wait_reg <= '0;
            tot_turn_reg <= '0;
        end
        else if (cmd.emit_next)
        begin
            k_reg <= k_reg + AW'(1);
        end
        else if (cmd.emit_fill)
        begin
            acc_reg      <= turn;
            tot_wait_reg <= tot_wait_reg + acc_reg;
            tot_turn_reg <= tot_turn_reg + turn;
        end

        if (cmd.emit_fill)
        begin
            job_number_reg       <= psw_pkg::NUM_W'(rd_num_reg);
            out_priority_reg     <= psw_pkg::PRIO_W'(rd_prio_reg);
            out_burst_reg        <= psw_pkg::BURST_W'(rd_burst_reg);
            wait_time_reg        <= acc_reg[psw_pkg::WAIT_W-1:0];
            turnaround_time_reg  <= turn[psw_pkg::WAIT_W-1:0];
            total_wait_reg       <= is_last ? tot_wait_reg + acc_reg : '0;
            total_turnaround_reg <= is_last ? tot_turn_reg + turn : '0;
            overflow_flag_reg    <= dropped_reg;
            last_result_reg      <= is_last;
        end
    end

    assign job_number       = job_number_reg;
    assign out_priority     = out_priority_reg;
    assign out_burst        = out_burst_reg;
    assign wait_time        = wait_time_reg;
    assign turnaround_time  = turnaround_time_reg;
    assign total_wait       = total_wait_reg;
    assign total_turnaround = total_turnaround_reg;
    assign overflow_flag    = overflow_flag_reg;
    assign last_result      = last_result_reg;

endmodule

### tb/sv/psw_service_order_checker.sv
`timescale 1ns / 100ps
// Checker for the priority schedule wait-time block: watches the job and result channels,
// predicts the service order and compares every result field by field.
// Depends on psw_pkg, psw_job_if and psw_result_if.
module psw_service_order_checker
#(
    parameter int MAX_JOBS = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    psw_job_if    job,
    psw_result_if result,
    output int    fail_count,
    output int    pending,
    output int    sets_seen,
    output int    results_checked,
    output int    dropped_jobs
);

    typedef struct packed {
        logic [psw_pkg::NUM_W-1:0]   number;
        logic [psw_pkg::PRIO_W-1:0]  prio;
        logic [psw_pkg::BURST_W-1:0] burst;
        logic [psw_pkg::WAIT_W-1:0]  waited;
        logic [psw_pkg::WAIT_W-1:0]  turnaround;
        logic [psw_pkg::TOTAL_W-1:0] wait_sum;
        logic [psw_pkg::TOTAL_W-1:0] turnaround_sum;
        logic                        overflow;
        logic                        last;
    } served_job_t;

    logic [psw_pkg::PRIO_W-1:0]  sorted_prio   [MAX_JOBS];
    logic [psw_pkg::BURST_W-1:0] sorted_burst  [MAX_JOBS];
    logic [psw_pkg::NUM_W-1:0]   sorted_number [MAX_JOBS];
    int                          stored;
    bit                          dropped;
    served_job_t                 service_order_due [$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic insert_job(input logic [psw_pkg::PRIO_W-1:0] p,
                              input logic [psw_pkg::BURST_W-1:0] b);
        int pos;
        pos = stored;
        while (pos > 0 && sorted_prio[pos-1] > p)
        begin
            sorted_prio[pos]   = sorted_prio[pos-1];
            sorted_burst[pos]  = sorted_burst[pos-1];
            sorted_number[pos] = sorted_number[pos-1];
            pos--;
        end
        sorted_prio[pos]   = p;
        sorted_burst[pos]  = b;
        sorted_number[pos] = psw_pkg::NUM_W'(stored + 1);
        stored++;
    endtask

    task automatic release_service_order();
        served_job_t                 s;
        logic [psw_pkg::WAIT_W-1:0]  waited;
        logic [psw_pkg::TOTAL_W-1:0] wait_total;
        logic [psw_pkg::TOTAL_W-1:0] turn_total;
        int                          k;
        waited     = '0;
        wait_total = '0;
        turn_total = '0;
        for (k = 0; k < stored; k++)
        begin
            s            = '0;
            s.number     = sorted_number[k];
            s.prio       = sorted_prio[k];
            s.burst      = sorted_burst[k];
            s.waited     = waited;
            s.turnaround = waited + psw_pkg::WAIT_W'(sorted_burst[k]);
            wait_total   = wait_total + psw_pkg::TOTAL_W'(s.waited);
            turn_total   = turn_total + psw_pkg::TOTAL_W'(s.turnaround);
            s.overflow   = dropped;
            s.last       = (k == stored - 1);
            if (s.last)
            begin
                s.wait_sum       = wait_total;
                s.turnaround_sum = turn_total;
            end
            service_order_due.push_back(s);
            waited = s.turnaround;
        end
        stored  = 0;
        dropped = 1'b0;
    endtask

    task automatic check_result();
        served_job_t want;
        if (service_order_due.size() == 0)
        begin
            report_mismatch($sformatf("result for job %0d arrived with none due",
                                      result.job_number));
            return;
        end
        want = service_order_due.pop_front();
        results_checked++;
        compare_field("job_number", 32'(result.job_number), 32'(want.number));
        compare_field("out_priority", 32'(result.out_priority), 32'(want.prio));
        compare_field("out_burst", 32'(result.out_burst), 32'(want.burst));
        compare_field("wait_time", 32'(result.wait_time), 32'(want.waited));
        compare_field("turnaround_time", 32'(result.turnaround_time),
                      32'(want.turnaround));
        compare_field("total_wait", 32'(result.total_wait), 32'(want.wait_sum));
        compare_field("total_turnaround", 32'(result.total_turnaround),
                      32'(want.turnaround_sum));
        compare_field("overflow_flag", 32'(result.overflow_flag), 32'(want.overflow));
        compare_field("last_result", 32'(result.last_result), 32'(want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored  = 0;
            dropped = 1'b0;
            service_order_due.delete();
            pending = 0;
        end
        else
        begin
            if (job.valid && job.ready)
            begin
                if (stored < MAX_JOBS)
                begin
                    insert_job(job.job_priority, job.burst_time);
                end
                else
                begin
                    dropped = 1'b1;
                    dropped_jobs++;
                end
                if (job.last_job)
                begin
                    release_service_order();
                    sets_seen++;
                end
            end
            if (result.valid && result.ready)
            begin
                check_result();
            end
            pending = service_order_due.size();
        end
    end

endmodule

### tb/sv/tb_priority_schedule_wait_times_core.sv
`timescale 1ns / 100ps
// Top of the testbench for priority_schedule_wait_times_core: drives job sets with random
// idling on both channels and gives the verdict from the checker's failure count.
// Depends on psw_pkg, psw_job_if, psw_result_if and psw_service_order_checker.
module tb_priority_schedule_wait_times_core;

    localparam int MAX_JOBS    = 64;
    localparam int ITEM_TARGET = 500;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   sets_seen;
    int   results_checked;
    int   dropped_jobs;
    int   items_sent;
    bit   steady;

    psw_job_if    job ();
    psw_result_if result ();

    priority_schedule_wait_times_core #(
        .MAX_JOBS  (MAX_JOBS),
        .TIME_BITS (16)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job),
        .result (result)
    );

    psw_service_order_checker #(
        .MAX_JOBS (MAX_JOBS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .job             (job),
        .result          (result),
        .fail_count      (fail_count),
        .pending         (pending),
        .sets_seen       (sets_seen),
        .results_checked (results_checked),
        .dropped_jobs    (dropped_jobs)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int draw_idle();
        if (steady || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(1, 18);
    endfunction

    function automatic logic [psw_pkg::PRIO_W-1:0] pick_priority(input int mode);
        case (mode)
            0:       return psw_pkg::PRIO_W'($urandom_range(0, 3));
            1:       return psw_pkg::PRIO_W'($urandom_range(0, 65535));
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'h0001;
                    2:       return 16'hFFFE;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    task automatic send_job(input logic [psw_pkg::PRIO_W-1:0] p,
                            input logic [psw_pkg::BURST_W-1:0] b,
                            input bit last);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            job.valid        = 1'b0;
            job.job_priority = psw_pkg::PRIO_W'($urandom);
            job.burst_time   = psw_pkg::BURST_W'($urandom);
            job.last_job     = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        job.valid        = 1'b1;
        job.job_priority = p;
        job.burst_time   = b;
        job.last_job     = last;
        @(posedge clk);
        while (!job.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    initial
    begin : result_sink
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_idle();
            if (stall > 0)
            begin
                result.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result.ready = 1'b1;
            @(posedge clk);
            while (!result.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin : job_source
        int directed;
        int sets_made;
        int kind;
        int size;
        int mode;
        int n;
        job.valid        = 1'b0;
        job.job_priority = '0;
        job.burst_time   = '0;
        job.last_job     = 1'b0;
        steady           = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single-job sets at both extremes, then ties, mixed bit patterns and equal extremes.
        send_job(16'h0000, 16'h0000, 1'b1);
        send_job(16'hFFFF, 16'hFFFF, 1'b1);
        steady = 1'b0;
        send_job(16'h0005, 16'h0003, 1'b0);
        send_job(16'h0005, 16'hFFFF, 1'b0);
        send_job(16'h0005, 16'h0000, 1'b0);
        send_job(16'h0004, 16'h0001, 1'b1);
        send_job(16'hFFFF, 16'hAAAA, 1'b0);
        send_job(16'h8000, 16'h5555, 1'b0);
        send_job(16'h0001, 16'hFFFF, 1'b0);
        send_job(16'h0000, 16'h0001, 1'b0);
        send_job(16'h5555, 16'h8000, 1'b0);
        send_job(16'hAAAA, 16'h7FFF, 1'b1);
        send_job(16'h0000, 16'hFFFF, 1'b0);
        send_job(16'h0000, 16'hFFFF, 1'b1);
        directed = items_sent;

        sets_made = 0;
        while (items_sent < directed + ITEM_TARGET)
        begin
            if (sets_made < 2)
            begin
                kind = sets_made;
            end
            else
            begin
                kind = $urandom_range(0, 24);
            end
            steady = ($urandom_range(0, 4) == 0);
            mode   = $urandom_range(0, 2);
            case (kind)
                0:       size = MAX_JOBS;
                1:       size = (sets_made == 1) ? MAX_JOBS + 1
                                                 : MAX_JOBS + $urandom_range(1, 3);
                default: size = $urandom_range(1, 10);
            endcase
            for (n = 0; n < size; n++)
            begin
                send_job(pick_priority(mode),
                         (kind == 0) ? 16'hFFFF
                                     : psw_pkg::BURST_W'($urandom_range(0, 65535)),
                         n == size - 1);
            end
            sets_made++;
        end
        job.valid = 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        $display("Sent %0d jobs in %0d sets, %0d of them dropped past capacity.",
                 items_sent, sets_seen, dropped_jobs);
        $display("Compared %0d served jobs against the predicted service order.",
                 results_checked);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Run stopped: results still outstanding after the time limit.");
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
design/psw_pkg.sv
design/psw_job_if.sv
design/psw_result_if.sv
design/psw_ctrl.sv
design/psw_datapath.sv
design/priority_schedule_wait_times_core.sv
tb/sv/psw_service_order_checker.sv
tb/sv/tb_priority_schedule_wait_times_core.sv
